/* src/cdp_pkg.sv */
// ----------------------------------------------------------------------------
// cdp_pkg
// Shared types and constants of the codebook delay-pattern core.
// ----------------------------------------------------------------------------
package cdp_pkg;

	localparam int LANES     = 8;
	localparam int TOK_W     = 16;
	localparam int FS_W      = 3;
	localparam int K_W       = 4;
	localparam int CFG_IDX_W = 2;

	typedef logic [TOK_W-1:0] token_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CODEBOOKS = 2'd0,
		REG_DIRECTION = 2'd1,
		REG_BEGIN_TOK = 2'd2,
		REG_END_TOK   = 2'd3
	} cfg_reg_t;

	localparam logic DIR_APPLY   = 1'b0;
	localparam logic DIR_REVERSE = 1'b1;

	typedef struct packed {
		logic [K_W-1:0] k;
		logic           dir;
		token_t         begin_tok;
		token_t         end_tok;
	} cfg_t;

	typedef struct packed {
		logic emit;
		logic eom;
		logic too_short;
		logic done;
	} step_t;

endpackage

/* src/cdp_history.sv */
// ----------------------------------------------------------------------------
// cdp_history
// Shift register of previous frames and the count of valid frames.
// ----------------------------------------------------------------------------
module cdp_history #(
	parameter int TB = 16,
	parameter int HD = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic                    clear,
	input  logic [TB-1:0]           frame [cdp_pkg::LANES],
	output logic [TB-1:0]           hist  [HD][cdp_pkg::LANES],
	output logic [cdp_pkg::FS_W-1:0] fs
);
	import cdp_pkg::*;

	logic [TB-1:0]   hist_q [HD][LANES];
	logic [FS_W-1:0] fs_q;

	always_ff @(posedge clk) begin
		if (push) begin
			hist_q[0] <= frame;
			for (int f = 1; f < HD; f++) begin
				hist_q[f] <= hist_q[f-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q <= '0;
		end else if (clear) begin
			fs_q <= '0;
		end else if (push && (fs_q < FS_W'(HD))) begin
			fs_q <= fs_q + 1'b1;
		end
	end

	assign hist = hist_q;
	assign fs   = fs_q;

endmodule

/* src/cdp_frame_mux.sv */
// ----------------------------------------------------------------------------
// cdp_frame_mux
// Selects each output lane from the current frame, the history or a fill
// token, and decides emission, flags and completion of the held item.
// ----------------------------------------------------------------------------
module cdp_frame_mux #(
	parameter int TB = 16,
	parameter int HD = 7
) (
	input  logic [TB-1:0]            tok  [cdp_pkg::LANES],
	input  logic [TB-1:0]            hist [HD][cdp_pkg::LANES],
	input  logic [cdp_pkg::FS_W-1:0] fs,
	input  cdp_pkg::cfg_t            cfg,
	input  logic                     fin,
	input  logic [cdp_pkg::FS_W-1:0] j,
	output cdp_pkg::token_t          lanes [cdp_pkg::LANES],
	output cdp_pkg::step_t           st
);
	import cdp_pkg::*;

	localparam int HIW = (HD > 1) ? $clog2(HD) : 1;

	logic           full;
	logic           last_j;
	logic [K_W-1:0] fs_x;
	logic [K_W-1:0] j_x;

	assign fs_x   = K_W'(fs);
	assign j_x    = K_W'(j);
	assign full   = (fs_x + 1'b1) >= cfg.k;
	assign last_j = j_x == (cfg.k - 1'b1);

	always_comb begin
		logic [K_W-1:0] lag;
		logic [HIW-1:0] hidx;
		logic [TB-1:0]  val;
		for (int l = 0; l < LANES; l++) begin
			lag  = '0;
			hidx = '0;
			val  = '0;
			lanes[l] = '0;
			if (K_W'(l) < cfg.k) begin
				if (cfg.dir == DIR_APPLY) begin
					lag = K_W'(l) - j_x;
				end else begin
					lag = cfg.k - 1'b1 - K_W'(l);
				end
				hidx = HIW'(lag - 1'b1);
				if (lag == '0) begin
					val = tok[l];
				end else if ((lag > fs_x) || (lag > K_W'(HD))) begin
					val = cfg.begin_tok[TB-1:0];
				end else begin
					val = hist[hidx][l];
				end
				if (cfg.dir == DIR_APPLY) begin
					if (K_W'(l) < j_x) begin
						lanes[l] = TOK_W'(cfg.end_tok[TB-1:0]);
					end else begin
						lanes[l] = TOK_W'(val);
					end
				end else if (full) begin
					lanes[l] = TOK_W'(val);
				end
			end
		end
	end

	always_comb begin
		if (cfg.dir == DIR_APPLY) begin
			st.emit      = 1'b1;
			st.eom       = fin && last_j;
			st.too_short = 1'b0;
			st.done      = !fin || last_j;
		end else begin
			st.emit      = full || fin;
			st.eom       = fin;
			st.too_short = !full;
			st.done      = 1'b1;
		end
	end

endmodule

/* src/codebook_delay_pattern_core.sv */
// ----------------------------------------------------------------------------
// codebook_delay_pattern_core
// Streaming delay-pattern coder for frames of up to eight codebook tokens.
// ----------------------------------------------------------------------------
// Takes one frame per cycle and gives one result frame per cycle while the
// output is not stalled. The final frame of a matrix in apply mode is held in
// the input register while its K results leave, one per cycle. In reverse
// mode the first K-1 frames give no result, save a final one, flagged
// too_short. An input item waits in the input register while the output
// register holds a result that has not been taken. The history is a shift
// register of min(MAX_CODEBOOKS, 8)-1 frames, at least one; it needs no
// clearing after reset. Config is to be written by the user only while the
// core is idle; the core itself does not enforce it.
module codebook_delay_pattern_core #(
	parameter int MAX_CODEBOOKS = 8,
	parameter int TOKEN_BITS    = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         cfg_we,
	input  logic [cdp_pkg::CFG_IDX_W-1:0]                cfg_addr,
	input  logic [cdp_pkg::TOK_W-1:0]                    cfg_wdata,
	input  logic                                         s_axis_tvalid,
	output logic                                         s_axis_tready,
	// tok0 .. tok7, 16 bits each
	input  logic [cdp_pkg::LANES*cdp_pkg::TOK_W-1:0]     s_axis_tdata,
	input  logic                                         s_axis_tlast,
	output logic                                         m_axis_tvalid,
	input  logic                                         m_axis_tready,
	// out0 .. out7, 16 bits each
	output logic [cdp_pkg::LANES*cdp_pkg::TOK_W-1:0]     m_axis_tdata,
	output logic                                         m_axis_tlast,
	// too_short
	output logic                                         m_axis_tuser
);
	import cdp_pkg::*;

	localparam int TB  = (TOKEN_BITS < TOK_W) ? TOKEN_BITS : TOK_W;
	localparam int NCB = (MAX_CODEBOOKS < LANES) ? MAX_CODEBOOKS : LANES;
	localparam int HD  = (NCB > 1) ? NCB - 1 : 1;

	logic [K_W-1:0]  cb_q;
	logic            dir_q;
	token_t          bt_q;
	token_t          et_q;
	cfg_t            cfg;

	logic            v_s1;
	logic [TB-1:0]   tok_s1 [LANES];
	logic            fin_s1;
	logic [FS_W-1:0] j_q;

	logic            m_v_q;
	token_t          out_q [LANES];
	logic            eom_q;
	logic            short_q;

	logic [TB-1:0]   hist [HD][LANES];
	logic [FS_W-1:0] fs;
	token_t          lanes [LANES];
	step_t           st;

	logic            out_free;
	logic            step;
	logic            accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cb_q  <= K_W'(8);
			dir_q <= DIR_APPLY;
			bt_q  <= TOK_W'(1024);
			et_q  <= TOK_W'(1025);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_CODEBOOKS: cb_q  <= cfg_wdata[K_W-1:0];
				REG_DIRECTION: dir_q <= cfg_wdata[0];
				REG_BEGIN_TOK: bt_q  <= cfg_wdata;
				REG_END_TOK:   et_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.dir       = dir_q;
		cfg.begin_tok = bt_q;
		cfg.end_tok   = et_q;
		if (cb_q == '0) begin
			cfg.k = K_W'(1);
		end else if (cb_q > K_W'(NCB)) begin
			cfg.k = K_W'(NCB);
		end else begin
			cfg.k = cb_q;
		end
	end

	assign out_free      = !m_v_q || m_axis_tready;
	assign step          = v_s1 && out_free;
	assign s_axis_tready = !v_s1 || (step && st.done);
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			j_q  <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (step && st.done) begin
				v_s1 <= 1'b0;
			end
			if (step) begin
				j_q <= st.done ? '0 : j_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int l = 0; l < LANES; l++) begin
				tok_s1[l] <= s_axis_tdata[l*TOK_W +: TB];
			end
			fin_s1 <= s_axis_tlast;
		end
	end

	cdp_history #(
		.TB (TB),
		.HD (HD)
	) u_history (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (step && st.done && !fin_s1),
		.clear  (step && st.done && fin_s1),
		.frame  (tok_s1),
		.hist   (hist),
		.fs     (fs)
	);

	cdp_frame_mux #(
		.TB (TB),
		.HD (HD)
	) u_frame_mux (
		.tok   (tok_s1),
		.hist  (hist),
		.fs    (fs),
		.cfg   (cfg),
		.fin   (fin_s1),
		.j     (j_q),
		.lanes (lanes),
		.st    (st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_v_q <= 1'b0;
		end else if (step && st.emit) begin
			m_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && st.emit) begin
			out_q   <= lanes;
			eom_q   <= st.eom;
			short_q <= st.too_short;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign m_axis_tdata[l*TOK_W +: TOK_W] = out_q[l];
	end

	assign m_axis_tvalid = m_v_q;
	assign m_axis_tlast  = eom_q;
	assign m_axis_tuser  = short_q;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for codebook_delay_pattern_core.
// Frames of eight tokens go in over the input stream and an in-bench model of
// the delay pattern predicts every result frame. Directed cases cover reset
// defaults, lane-count clamping, K=1, too-short reverse matrices and a config
// change in the middle of a matrix. Random phases follow, each with a new
// config. Both sides idle in random bursts, except in the last part.
// ----------------------------------------------------------------------------
module testbench;
	import cdp_pkg::*;

	localparam int FRAME_W      = LANES * TOK_W;
	localparam int RANDOM_ITEMS = 150;
	localparam int TAIL_CYCLES  = 8;

	typedef struct packed {
		logic [FRAME_W-1:0] data;
		logic               eom;
		logic               shrt;
	} exp_frame_t;

	// in-bench model of the delay pattern plus the queue of expected frames
	class delay_pattern_scoreboard;
		cfg_t        cfg;
		token_t      hist[LANES-1][LANES];
		int unsigned seen;
		exp_frame_t  pending[$];
		int          errors;
		int          frames_in;
		int          frames_out;
		int          apply_mats;
		int          reverse_mats;
		int          short_results;

		function new();
			cfg = '{k: 4'd8, dir: DIR_APPLY, begin_tok: 16'd1024, end_tok: 16'd1025};
			seen = 0;
			errors = 0;
			frames_in = 0;
			frames_out = 0;
			apply_mats = 0;
			reverse_mats = 0;
			short_results = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, token_t v);
			case (idx)
				REG_CODEBOOKS: cfg.k = v[K_W-1:0];
				REG_DIRECTION: cfg.dir = v[0];
				REG_BEGIN_TOK: cfg.begin_tok = v;
				REG_END_TOK:   cfg.end_tok = v;
				default: ;
			endcase
		endfunction

		// token of a lane, lag frames back in the current matrix
		function token_t tap(logic [FRAME_W-1:0] cur, int lag, int lane);
			if (lag == 0)
				return cur[lane*TOK_W +: TOK_W];
			if (lag > int'(seen))
				return cfg.begin_tok;
			return hist[lag-1][lane];
		endfunction

		function void note_frame(logic [FRAME_W-1:0] cur, logic fin);
			int         nk;
			exp_frame_t e;
			nk = (cfg.k == 0) ? 1 : ((cfg.k > LANES) ? LANES : int'(cfg.k));
			frames_in++;
			if (cfg.dir == DIR_APPLY) begin
				e = '0;
				for (int k = 0; k < nk; k++)
					e.data[k*TOK_W +: TOK_W] = tap(cur, k, k);
				e.eom = fin && (nk == 1);
				pending.push_back(e);
				if (fin) begin
					for (int j = 1; j < nk; j++) begin
						e = '0;
						for (int k = 0; k < nk; k++)
							e.data[k*TOK_W +: TOK_W] = (k >= j) ? tap(cur, k - j, k) : cfg.end_tok;
						e.eom = (j == nk - 1);
						pending.push_back(e);
					end
					apply_mats++;
				end
			end else begin
				e = '0;
				if (int'(seen) + 1 >= nk) begin
					for (int k = 0; k < nk; k++)
						e.data[k*TOK_W +: TOK_W] = tap(cur, nk - 1 - k, k);
					e.eom = fin;
					pending.push_back(e);
				end else if (fin) begin
					e.eom = 1'b1;
					e.shrt = 1'b1;
					pending.push_back(e);
				end
				if (fin)
					reverse_mats++;
			end
			if (fin) begin
				seen = 0;
			end else begin
				for (int f = LANES - 2; f > 0; f--)
					hist[f] = hist[f-1];
				for (int k = 0; k < LANES; k++)
					hist[0][k] = cur[k*TOK_W +: TOK_W];
				if (seen < LANES - 1)
					seen++;
			end
		endfunction

		function void check_frame(logic [FRAME_W-1:0] data, logic last, logic user);
			exp_frame_t e;
			frames_out++;
			if (pending.size() == 0) begin
				$error("result with nothing expected: tdata %h tlast %b tuser %b",
					data, last, user);
				errors++;
				return;
			end
			e = pending.pop_front();
			for (int k = 0; k < LANES; k++) begin
				if (data[k*TOK_W +: TOK_W] !== e.data[k*TOK_W +: TOK_W]) begin
					$error("out%0d: expected %h, actual %h", k,
						e.data[k*TOK_W +: TOK_W], data[k*TOK_W +: TOK_W]);
					errors++;
				end
			end
			if (last !== e.eom) begin
				$error("end_of_matrix: expected %b, actual %b", e.eom, last);
				errors++;
			end
			if (user !== e.shrt) begin
				$error("too_short: expected %b, actual %b", e.shrt, user);
				errors++;
			end
			if (e.shrt)
				short_results++;
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [TOK_W-1:0]     cfg_wdata = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [FRAME_W-1:0]   s_axis_tdata = '0;
	logic                 s_axis_tlast = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [FRAME_W-1:0]   m_axis_tdata;
	logic                 m_axis_tlast;
	logic                 m_axis_tuser;

	bit gap_en = 1'b1;
	bit stall_en = 1'b1;

	delay_pattern_scoreboard sb = new();

	codebook_delay_pattern_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_frame(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_frame(m_axis_tdata, m_axis_tlast, m_axis_tuser);
		end
	end

	// output back-pressure
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (stall_en && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		#5_000_000;
		$display("timeout: %0d results still expected", sb.pending.size());
		$display("status: fail");
		$finish;
	end

	function automatic token_t rand_tok();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return token_t'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [FRAME_W-1:0] rand_frame();
		logic [FRAME_W-1:0] f;
		for (int k = 0; k < LANES; k++)
			f[k*TOK_W +: TOK_W] = rand_tok();
		return f;
	endfunction

	task automatic cfg_write(input cfg_reg_t idx, input token_t v);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_reg(idx, v);
	endtask

	task automatic set_config(input logic [K_W-1:0] k, input logic dir, input token_t bt,
			input token_t et);
		cfg_write(REG_CODEBOOKS, token_t'(k));
		cfg_write(REG_DIRECTION, token_t'(dir));
		cfg_write(REG_BEGIN_TOK, bt);
		cfg_write(REG_END_TOK, et);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_frame(input logic [FRAME_W-1:0] d, input logic fin);
		if (gap_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tlast <= fin;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_matrix(input int len);
		for (int i = 0; i < len; i++)
			send_frame(rand_frame(), i == len - 1);
	endtask

	// hold the input until every expected frame is out, then let the pipe drain
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	initial begin
		int               total;
		logic [K_W-1:0]   k;
		logic             dir;
		int               len;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: K=8, apply, begin 1024, end 1025
		send_frame({LANES{16'h0000}}, 1'b0);
		send_frame({LANES{16'hFFFF}}, 1'b0);
		send_frame({4{16'h5555, 16'hAAAA}}, 1'b1);
		wait_idle();

		// single lane, a single-frame and a two-frame matrix
		set_config(4'd1, DIR_APPLY, 16'h0000, 16'hFFFF);
		send_frame(rand_frame(), 1'b1);
		send_matrix(2);
		wait_idle();

		// lane count 0 acts as 1
		set_config(4'd0, DIR_APPLY, 16'hFFFF, 16'h0000);
		send_matrix(2);
		wait_idle();

		// lane count above 8 clamps; too-short reverse matrices
		set_config(4'd15, DIR_REVERSE, rand_tok(), rand_tok());
		send_matrix(3);
		send_matrix(1);
		wait_idle();

		set_config(4'd4, DIR_REVERSE, rand_tok(), rand_tok());
		send_matrix(6);
		wait_idle();

		set_config(4'd1, DIR_REVERSE, rand_tok(), rand_tok());
		send_matrix(2);
		wait_idle();

		// config change in the middle of a matrix
		set_config(4'd5, DIR_APPLY, 16'h1234, 16'h4321);
		send_frame(rand_frame(), 1'b0);
		send_frame(rand_frame(), 1'b0);
		wait_idle();
		set_config(4'd3, DIR_APPLY, 16'h0000, 16'hFFFF);
		send_frame(rand_frame(), 1'b0);
		send_frame(rand_frame(), 1'b1);
		wait_idle();

		total = sb.frames_in + RANDOM_ITEMS;
		while (sb.frames_in < total) begin
			case ($urandom_range(0, 7))
				0:       k = 4'd0;
				1:       k = K_W'($urandom_range(9, 15));
				2:       k = 4'd8;
				3:       k = 4'd1;
				default: k = K_W'($urandom_range(1, 8));
			endcase
			dir = $urandom_range(0, 1) ? DIR_REVERSE : DIR_APPLY;
			gap_en = (sb.frames_in <= total - 40) && ($urandom_range(0, 3) != 0);
			stall_en = (sb.frames_in <= total - 40) && ($urandom_range(0, 3) != 0);
			set_config(k, dir, rand_tok(), rand_tok());
			repeat ($urandom_range(1, 3)) begin
				if (sb.frames_in > total - 40) begin
					gap_en = 1'b0;
					stall_en = 1'b0;
				end
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 8);
				send_matrix(len);
			end
			wait_idle();
		end

		foreach (sb.pending[i]) begin
			$error("expected result never came: tdata %h", sb.pending[i].data);
			sb.errors++;
		end
		$display("ran %0d input frames, checked %0d result frames (%0d too-short)",
			sb.frames_in, sb.frames_out, sb.short_results);
		$display("matrices: %0d apply, %0d reverse, with clamped and extreme lane counts",
			sb.apply_mats, sb.reverse_mats);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
